/* hw/rtl/ppi_pkg.sv */
// ppi_pkg: request and response types and register codes shared by the
// parallel port interface modules. No dependencies.
package ppi_pkg;

  localparam int unsigned NumPorts = 3;

  // access kind
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // register select codes
  localparam logic [1:0] REG_PORT_A  = 2'd0;
  localparam logic [1:0] REG_PORT_B  = 2'd1;
  localparam logic [1:0] REG_PORT_C  = 2'd2;
  localparam logic [1:0] REG_CONTROL = 2'd3;

  typedef struct packed {
    logic       op;
    logic [1:0] reg_select;
    logic [7:0] wr_byte;
    logic [7:0] pins_a;
    logic [7:0] pins_b;
    logic [7:0] pins_c;
  } ppi_req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] drive_a;
    logic [7:0] drive_b;
    logic [7:0] drive_c;
    logic       strobe_a;
    logic       strobe_b;
    logic       strobe_c;
    logic       mode_rejected;
  } ppi_rsp_t;

endpackage

/* hw/rtl/ppi_req_stage.sv */
// ppi_req_stage: input register for bus requests with valid/ready control.
// Depends on ppi_pkg for the request type.
module ppi_req_stage import ppi_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  ppi_req_t req,
  input  logic     advance,
  output logic     stage_valid,
  output ppi_req_t stage_req
);

  logic     valid;
  ppi_req_t held;

  // take a new request when empty or when the held one moves on this cycle
  assign req_ready = !valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (req_ready) begin
      valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      held <= req;
    end
  end

  assign stage_valid = valid;
  assign stage_req   = held;

endmodule

/* hw/rtl/ppi_engine.sv */
// ppi_engine: port latches and direction masks, with the read, write and
// control word logic that produces one response per request. Uses ppi_pkg.
module ppi_engine import ppi_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     fire,
  input  ppi_req_t req,
  output ppi_rsp_t rsp
);

  localparam logic [7:0] AllOnes    = 8'hFF;
  localparam logic [7:0] UpperNib   = 8'hF0;
  localparam logic [7:0] LowerNib   = 8'h0F;
  localparam logic [7:0] Mode2CIn   = 8'hF7;
  localparam logic [1:0] GroupAMode0 = 2'd0;
  localparam logic [1:0] GroupAMode1 = 2'd1;

  logic [NumPorts-1:0][7:0] latch, latch_next;
  logic [NumPorts-1:0][7:0] imask, imask_next;
  logic [NumPorts-1:0][7:0] omask, omask_next;

  function automatic logic [7:0] port_read(input logic [7:0] pins, input logic [7:0] l,
                                           input logic [7:0] im, input logic [7:0] om);
    port_read = (pins & im) | (l & om & ~im);
  endfunction

  function automatic logic [7:0] port_drive(input logic [7:0] l, input logic [7:0] om);
    port_drive = (l & om) | ~om;
  endfunction

  always_comb begin
    logic [1:0] ga;
    logic       gb;
    logic [7:0] rd;
    logic       sa, sb, sc, rej;
    latch_next = latch;
    imask_next = imask;
    omask_next = omask;
    rd  = '0;
    sa  = 1'b0;
    sb  = 1'b0;
    sc  = 1'b0;
    rej = 1'b0;
    ga  = req.wr_byte[6:5];
    gb  = req.wr_byte[2];
    if (req.op == OP_READ) begin
      unique case (req.reg_select)
        REG_PORT_A:  rd = port_read(req.pins_a, latch[0], imask[0], omask[0]);
        REG_PORT_B:  rd = port_read(req.pins_b, latch[1], imask[1], omask[1]);
        REG_PORT_C:  rd = port_read(req.pins_c, latch[2], imask[2], omask[2]);
        REG_CONTROL: rd = AllOnes;
      endcase
    end else if (req.reg_select != REG_CONTROL) begin
      unique case (req.reg_select)
        REG_PORT_A: begin
          latch_next[0] = req.wr_byte;
          sa = 1'b1;
        end
        REG_PORT_B: begin
          latch_next[1] = req.wr_byte;
          sb = 1'b1;
        end
        default: begin
          latch_next[2] = req.wr_byte;
          sc = 1'b1;
        end
      endcase
    end else if (req.wr_byte[7]) begin
      // mode word
      if (ga == GroupAMode1 || gb) begin
        rej = 1'b1;
      end else begin
        if (ga == GroupAMode0) begin
          if (req.wr_byte[4]) begin
            imask_next[0] = AllOnes;
            omask_next[0] = '0;
          end else begin
            imask_next[0] = '0;
            omask_next[0] = AllOnes;
          end
          if (req.wr_byte[3]) begin
            imask_next[2] = imask_next[2] | UpperNib;
            omask_next[2] = omask_next[2] & LowerNib;
          end else begin
            imask_next[2] = imask_next[2] & LowerNib;
            omask_next[2] = omask_next[2] | UpperNib;
          end
        end else begin
          // mode 2/3 approximation on group A
          imask_next[0] = AllOnes;
          omask_next[0] = AllOnes;
          imask_next[2] = Mode2CIn;
          omask_next[2] = AllOnes;
        end
        if (req.wr_byte[1]) begin
          imask_next[1] = AllOnes;
          omask_next[1] = '0;
        end else begin
          imask_next[1] = '0;
          omask_next[1] = AllOnes;
        end
        if (req.wr_byte[0]) begin
          imask_next[2] = imask_next[2] | LowerNib;
          omask_next[2] = omask_next[2] & UpperNib;
        end else begin
          imask_next[2] = imask_next[2] & UpperNib;
          omask_next[2] = omask_next[2] | LowerNib;
        end
        latch_next = '0;
        sa = 1'b1;
        sb = 1'b1;
        sc = 1'b1;
      end
    end else begin
      // port C bit set/reset
      latch_next[2][req.wr_byte[3:1]] = req.wr_byte[0];
      sc = 1'b1;
    end

    rsp.read_data     = rd;
    rsp.drive_a       = port_drive(latch_next[0], omask_next[0]);
    rsp.drive_b       = port_drive(latch_next[1], omask_next[1]);
    rsp.drive_c       = port_drive(latch_next[2], omask_next[2]);
    rsp.strobe_a      = sa;
    rsp.strobe_b      = sb;
    rsp.strobe_c      = sc;
    rsp.mode_rejected = rej;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      latch <= '0;
      imask <= {NumPorts{AllOnes}};
      omask <= '0;
    end else if (fire) begin
      latch <= latch_next;
      imask <= imask_next;
      omask <= omask_next;
    end
  end

endmodule

/* hw/rtl/parallel_port_interface_unit.sv */
// parallel_port_interface_unit: top level of the three-port parallel interface.
// Depends on ppi_pkg, ppi_req_stage and ppi_engine.
//
// Usage:
//   A request is one bus access (read or write to port A, B, C or control)
//   together with the pin levels of all three ports. It is taken on req
//   when req_valid and req_ready are both high at a rising edge of clk.
//   Each request gives exactly one response on rsp, taken when rsp_valid
//   and rsp_ready are both high. Responses come out in request order.
//   Path: an accepted request waits in the input register; the engine
//   works on it combinationally, and its response is registered in the
//   output register, from which it is offered on rsp.
//   Throughput: one request per cycle when not stalled; the engine updates
//   the latches and masks in a single pass between the input and output registers.
//   Stall: while rsp_ready is low the response holds in the output
//   register, one more request may wait in the input register, and then
//   req_ready drops until the response is taken.
//   Reset (rst, synchronous, active high) empties both registers and puts
//   all ports in mode 0 as inputs with cleared latches.
module parallel_port_interface_unit import ppi_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  ppi_req_t req,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output ppi_rsp_t rsp
);

  logic     stage_valid;
  ppi_req_t stage_req;
  logic     advance;
  ppi_rsp_t rsp_comb;
  logic     out_valid;
  ppi_rsp_t out_rsp;

  assign advance = stage_valid && (!out_valid || rsp_ready);

  ppi_req_stage u_req_stage (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req),
    .advance     (advance),
    .stage_valid (stage_valid),
    .stage_req   (stage_req)
  );

  ppi_engine u_engine (
    .clk  (clk),
    .rst  (rst),
    .fire (advance),
    .req  (stage_req),
    .rsp  (rsp_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || rsp_ready) begin
      out_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_rsp <= rsp_comb;
    end
  end

  assign rsp_valid = out_valid;
  assign rsp       = out_rsp;

  // a held request stays put until it moves to the output register
  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    stage_valid && !advance |=> stage_valid && $stable(stage_req))
    else $error("input register lost a request while stalled");

  // reads never strobe and never reject
  a_read_quiet: assert property (@(posedge clk) disable iff (rst)
    advance && stage_req.op == OP_READ |=>
      !rsp.strobe_a && !rsp.strobe_b && !rsp.strobe_c && !rsp.mode_rejected)
    else $error("read request produced a strobe or rejection");

  // writes return zero read data
  a_write_zero: assert property (@(posedge clk) disable iff (rst)
    advance && stage_req.op == OP_WRITE |=> rsp.read_data == 8'h00)
    else $error("write request returned nonzero read data");

  // a rejected mode word changes nothing
  a_reject_no_strobe: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.mode_rejected |-> !rsp.strobe_a && !rsp.strobe_b && !rsp.strobe_c)
    else $error("rejected mode word strobed a port");

endmodule

/* verif/parallel_port_interface_unit_test.sv */
// parallel_port_interface_unit_test: self-checking testbench for the three-port
// parallel interface. Depends on ppi_pkg and parallel_port_interface_unit; it
// predicts each response from its own model of the latches and masks.
`timescale 1ns / 100ps

module parallel_port_interface_unit_test;
  import ppi_pkg::*;

  localparam int CycleLimit    = 200000;
  localparam int RandomPerRun  = 475;
  localparam int MaxReported   = 10;

  // control word fields
  localparam int         ModeFlagBit  = 7;
  localparam logic [1:0] GroupAMode1  = 2'd1;
  localparam logic [1:0] GroupAMode0  = 2'd0;
  localparam logic [1:0] GroupAMode2  = 2'd2;
  localparam logic [1:0] GroupAMode3  = 2'd3;
  localparam logic       GroupBMode1  = 1'b1;

  logic     clk;
  logic     rst;
  logic     req_valid;
  logic     req_ready;
  ppi_req_t req;
  logic     rsp_valid;
  logic     rsp_ready;
  ppi_rsp_t rsp;

  parallel_port_interface_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // predicted chip state
  logic [7:0] latch_q    [NumPorts];
  logic [7:0] in_mask_q  [NumPorts];
  logic [7:0] out_mask_q [NumPorts];

  ppi_rsp_t pending_rsps[$];
  int       mismatches;
  int       cycle_count;
  int       send_idle_pct;
  int       rsp_stall_pct;
  int       hold_cycles;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [7:0] drive_value(logic [1:0] p);
    return (latch_q[p] & out_mask_q[p]) | ~out_mask_q[p];
  endfunction

  function automatic void reset_port_state();
    for (int p = 0; p < NumPorts; p++) begin
      latch_q[p]    = 8'h00;
      in_mask_q[p]  = 8'hFF;
      out_mask_q[p] = 8'h00;
    end
  endfunction

  // returns 0 when the mode word asks for mode 1 and is refused
  function automatic bit apply_mode_word(logic [6:0] w);
    logic [1:0] ga;
    logic       gb;
    ga = w[6:5];
    gb = w[2];
    if (ga == GroupAMode1 || gb == GroupBMode1) return 1'b0;
    if (ga == GroupAMode0) begin
      if (w[4]) begin
        in_mask_q[REG_PORT_A] = 8'hFF; out_mask_q[REG_PORT_A] = 8'h00;
      end else begin
        in_mask_q[REG_PORT_A] = 8'h00; out_mask_q[REG_PORT_A] = 8'hFF;
      end
      if (w[3]) begin
        in_mask_q[REG_PORT_C] |= 8'hF0; out_mask_q[REG_PORT_C] &= 8'h0F;
      end else begin
        in_mask_q[REG_PORT_C] &= 8'h0F; out_mask_q[REG_PORT_C] |= 8'hF0;
      end
    end else begin
      // mode 2/3 approximation on group A
      in_mask_q[REG_PORT_A] = 8'hFF; out_mask_q[REG_PORT_A] = 8'hFF;
      in_mask_q[REG_PORT_C] = 8'hF7; out_mask_q[REG_PORT_C] = 8'hFF;
    end
    if (w[1]) begin
      in_mask_q[REG_PORT_B] = 8'hFF; out_mask_q[REG_PORT_B] = 8'h00;
    end else begin
      in_mask_q[REG_PORT_B] = 8'h00; out_mask_q[REG_PORT_B] = 8'hFF;
    end
    if (w[0]) begin
      in_mask_q[REG_PORT_C] |= 8'h0F; out_mask_q[REG_PORT_C] &= 8'hF0;
    end else begin
      in_mask_q[REG_PORT_C] &= 8'hF0; out_mask_q[REG_PORT_C] |= 8'h0F;
    end
    for (int p = 0; p < NumPorts; p++) latch_q[p] = 8'h00;
    return 1'b1;
  endfunction

  function automatic ppi_rsp_t compute_port_response(ppi_req_t r);
    ppi_rsp_t   o;
    logic [7:0] pins [NumPorts];
    pins[REG_PORT_A] = r.pins_a;
    pins[REG_PORT_B] = r.pins_b;
    pins[REG_PORT_C] = r.pins_c;
    o = '0;
    if (r.op == OP_READ) begin
      if (r.reg_select == REG_CONTROL) begin
        o.read_data = 8'hFF;
      end else begin
        o.read_data = (pins[r.reg_select] & in_mask_q[r.reg_select]) |
                      (latch_q[r.reg_select] & out_mask_q[r.reg_select] &
                       ~in_mask_q[r.reg_select]);
      end
    end else if (r.reg_select != REG_CONTROL) begin
      latch_q[r.reg_select] = r.wr_byte;
      case (r.reg_select)
        REG_PORT_A: o.strobe_a = 1'b1;
        REG_PORT_B: o.strobe_b = 1'b1;
        default:    o.strobe_c = 1'b1;
      endcase
    end else if (r.wr_byte[ModeFlagBit]) begin
      if (apply_mode_word(r.wr_byte[6:0])) begin
        o.strobe_a = 1'b1;
        o.strobe_b = 1'b1;
        o.strobe_c = 1'b1;
      end else begin
        o.mode_rejected = 1'b1;
      end
    end else begin
      // single bit set/reset on port C
      latch_q[REG_PORT_C][r.wr_byte[3:1]] = r.wr_byte[0];
      o.strobe_c = 1'b1;
    end
    o.drive_a = drive_value(REG_PORT_A);
    o.drive_b = drive_value(REG_PORT_B);
    o.drive_c = drive_value(REG_PORT_C);
    return o;
  endfunction

  function automatic ppi_req_t make_access(logic op, logic [1:0] sel, logic [7:0] data,
                                           logic [7:0] pa, logic [7:0] pb,
                                           logic [7:0] pc);
    ppi_req_t r;
    r.op         = op;
    r.reg_select = sel;
    r.wr_byte    = data;
    r.pins_a     = pa;
    r.pins_b     = pb;
    r.pins_c     = pc;
    return r;
  endfunction

  function automatic ppi_req_t random_access();
    ppi_req_t    r;
    int          pick;
    logic [1:0]  ga;
    logic [63:0] noise;
    noise = {$urandom, $urandom};
    r = noise[$bits(ppi_req_t)-1:0];
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      r.op = OP_READ;
    end else if (pick < 60) begin
      r.op = OP_WRITE;
      r.reg_select = 2'($urandom_range(REG_PORT_A, REG_PORT_C));
    end else if (pick < 80) begin
      // mode word, mostly a supported mode
      r.op = OP_WRITE;
      r.reg_select = REG_CONTROL;
      r.wr_byte[ModeFlagBit] = 1'b1;
      case ($urandom_range(0, 9))
        0:       ga = GroupAMode1;
        1, 2:    ga = GroupAMode2;
        3:       ga = GroupAMode3;
        default: ga = GroupAMode0;
      endcase
      r.wr_byte[6:5] = ga;
      r.wr_byte[2]   = ($urandom_range(0, 9) == 0);
    end else begin
      r.op = OP_WRITE;
      r.reg_select = REG_CONTROL;
      r.wr_byte[ModeFlagBit] = 1'b0;
    end
    return r;
  endfunction

  task automatic send_request(input ppi_req_t r);
    logic [63:0] noise;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      noise     = {$urandom, $urandom};
      req_valid = 1'b0;
      req       = noise[$bits(ppi_req_t)-1:0];
      @(negedge clk);
    end
    req_valid = 1'b1;
    req       = r;
    do @(posedge clk); while (!req_ready);
    pending_rsps.push_back(compute_port_response(r));
  endtask

  task automatic drain_responses();
    @(negedge clk);
    req_valid = 1'b0;
    while (pending_rsps.size() != 0) @(posedge clk);
  endtask

  // receiver: random stalls plus an optional long hold-off
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      rsp_ready   = 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      rsp_ready = ($urandom_range(0, 99) >= rsp_stall_pct);
    end
  end

  function automatic void report_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
    if (exp_v !== got_v) begin
      mismatches++;
      if (mismatches <= MaxReported)
        $display("mismatch %s: expected %02h got %02h at %0t", name, exp_v, got_v, $realtime);
    end
  endfunction

  always @(posedge clk) begin
    ppi_rsp_t exp_rsp;
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_rsps.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReported)
          $display("unexpected response %h at %0t", rsp, $realtime);
      end else begin
        exp_rsp = pending_rsps.pop_front();
        report_field("read_data", exp_rsp.read_data, rsp.read_data);
        report_field("drive_a", exp_rsp.drive_a, rsp.drive_a);
        report_field("drive_b", exp_rsp.drive_b, rsp.drive_b);
        report_field("drive_c", exp_rsp.drive_c, rsp.drive_c);
        report_field("strobe_a", 8'(exp_rsp.strobe_a), 8'(rsp.strobe_a));
        report_field("strobe_b", 8'(exp_rsp.strobe_b), 8'(rsp.strobe_b));
        report_field("strobe_c", 8'(exp_rsp.strobe_c), 8'(rsp.strobe_c));
        report_field("mode_rejected", 8'(exp_rsp.mode_rejected), 8'(rsp.mode_rejected));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("parallel_port_interface_unit verification failed");
      $finish;
    end
  end

  task automatic test_reset_reads();
    send_request(make_access(OP_READ, REG_PORT_A, 8'h00, 8'hFF, 8'h00, 8'h00));
    send_request(make_access(OP_READ, REG_PORT_B, 8'hFF, 8'h00, 8'hFF, 8'h00));
    send_request(make_access(OP_READ, REG_PORT_C, 8'h00, 8'h00, 8'h00, 8'hA5));
    send_request(make_access(OP_READ, REG_CONTROL, 8'h00, 8'h5A, 8'h5A, 8'h5A));
  endtask

  task automatic test_all_outputs();
    send_request(make_access(OP_WRITE, REG_CONTROL, 8'h80, 8'h00, 8'h00, 8'h00));
    send_request(make_access(OP_WRITE, REG_PORT_A, 8'hFF, 8'h00, 8'h00, 8'h00));
    send_request(make_access(OP_WRITE, REG_PORT_B, 8'h00, 8'hFF, 8'hFF, 8'hFF));
    send_request(make_access(OP_WRITE, REG_PORT_C, 8'hA5, 8'h00, 8'h00, 8'h00));
    send_request(make_access(OP_READ, REG_PORT_A, 8'h00, 8'h00, 8'hFF, 8'hFF));
    send_request(make_access(OP_READ, REG_PORT_B, 8'h00, 8'hFF, 8'hFF, 8'hFF));
    send_request(make_access(OP_READ, REG_PORT_C, 8'h00, 8'hFF, 8'hFF, 8'h00));
  endtask

  task automatic test_bit_set_reset();
    send_request(make_access(OP_WRITE, REG_CONTROL, 8'h0F, 8'h00, 8'h00, 8'h00));
    send_request(make_access(OP_WRITE, REG_CONTROL, 8'h70, 8'hFF, 8'hFF, 8'hFF));
  endtask

  task automatic test_mode_words();
    // mode 1 on either group is refused
    send_request(make_access(OP_WRITE, REG_CONTROL, 8'hA0, 8'h00, 8'h00, 8'h00));
    send_request(make_access(OP_WRITE, REG_CONTROL, 8'h84, 8'h00, 8'h00, 8'h00));
    send_request(make_access(OP_WRITE, REG_CONTROL, 8'hC0, 8'h00, 8'h00, 8'h00));
    send_request(make_access(OP_WRITE, REG_PORT_A, 8'h3C, 8'h00, 8'h00, 8'h00));
    send_request(make_access(OP_READ, REG_PORT_A, 8'h00, 8'hC3, 8'h00, 8'h00));
    send_request(make_access(OP_WRITE, REG_CONTROL, 8'hFF, 8'h00, 8'h00, 8'h00));
    send_request(make_access(OP_READ, REG_PORT_C, 8'h00, 8'h00, 8'h00, 8'hFF));
    send_request(make_access(OP_WRITE, REG_CONTROL, 8'h9B, 8'h00, 8'h00, 8'h00));
    send_request(make_access(OP_READ, REG_PORT_B, 8'h00, 8'h00, 8'h81, 8'h00));
    send_request(make_access(OP_READ, REG_CONTROL, 8'h00, 8'h00, 8'h00, 8'h00));
  endtask

  task automatic test_random_run(int idle_pct, int stall_pct);
    send_idle_pct = idle_pct;
    rsp_stall_pct = stall_pct;
    for (int i = 0; i < RandomPerRun; i++) send_request(random_access());
    drain_responses();
  endtask

  // long receiver hold-off while requests keep coming, so the input stalls
  task automatic test_backpressure();
    send_idle_pct = 0;
    rsp_stall_pct = 0;
    hold_cycles   = 80;
    for (int i = 0; i < 30; i++) send_request(random_access());
    drain_responses();
  endtask

  initial begin
    clk           = 1'b0;
    rst           = 1'b1;
    req_valid     = 1'b0;
    req           = '0;
    rsp_ready     = 1'b0;
    mismatches    = 0;
    cycle_count   = 0;
    send_idle_pct = 0;
    rsp_stall_pct = 0;
    hold_cycles   = 0;
    reset_port_state();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_reads();
    test_all_outputs();
    test_bit_set_reset();
    test_mode_words();
    drain_responses();
    test_random_run(0, 0);
    test_random_run(51, 0);
    test_random_run(0, 51);
    test_backpressure();
    test_random_run(10, 10);

    rsp_stall_pct = 0;
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("parallel_port_interface_unit verification clean");
    end else begin
      $display("parallel_port_interface_unit verification failed");
    end
    $finish;
  end

endmodule
